/* rtl/ppmsd_pkg.sv */
// Shared types and constants of the PPM-sum decoder.
package ppmsd_pkg;

    // Item action codes.
    localparam logic [1:0] ACTION_RISE = 2'd0;
    localparam logic [1:0] ACTION_FALL = 2'd1;
    localparam logic [1:0] ACTION_PORT = 2'd2;

    // Register numbers with a special meaning on the serial port.
    localparam logic [6:0] REG_READY       = 7'h7f;
    localparam logic [6:0] REG_CLEAR_READY = 7'h7e;

    // Saturation limit of one half period.
    localparam logic [15:0] PERIOD_MAX = 16'hffff;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_WIDTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WIDTH    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CHANNELS = 2'd3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] SYNC_WIDTH_RESET   = 16'd2700;
    localparam logic [15:0] MIN_WIDTH_RESET    = 16'd800;
    localparam logic [15:0] MAX_WIDTH_RESET    = 16'd2200;
    localparam logic [3:0]  MIN_CHANNELS_RESET = 4'd5;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PAIR,
        ST_PULSE,
        ST_COPY,
        ST_READ,
        ST_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic edge_step;
        logic pair_step;
        logic pulse_step;
        logic copy_step;
        logic port_step;
        logic read_done;
        logic load_result;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic       bank_read;
        logic       have_pair;
        logic       publish;
        logic       copy_none;
        logic       copy_last;
    } dp_status_t;

endpackage

/* rtl/ppmsd_if.sv */
// Channel interfaces of the PPM-sum decoder: input items and result items.
interface ppmsd_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] edge_time;
    logic [15:0] port_frame;

    modport source (output valid, output action, output edge_time, output port_frame,
                    input ready);
    modport sink (input valid, input action, input edge_time, input port_frame,
                  output ready);
endinterface

interface ppmsd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_ready;

    modport source (output valid, output tx_byte, output frame_ready, input ready);
    modport sink (input valid, input tx_byte, input frame_ready, output ready);
endinterface

/* rtl/ppm_sum_decoder_with_register_port.sv */
// Top level of the PPM-sum decoder with a byte-wide register port.
//
// Each input transaction is a rising edge, a falling edge or a serial port frame, and
// yields exactly one result transaction carrying the reply byte for the next serial
// frame and the frame-ready flag. Items are processed one at a time. An edge passes
// through the execute and pair states, then the pulse state when it completes a pulse,
// and the copy state when it publishes a frame of n channels, where the frame copy
// writes one byte per cycle through the single write port of the register bank. A
// bank read passes through an extra read state for the registered memory read. The
// result is loaded only once the output register is free, so a stalled receiver holds
// the block in its final state. The next item is accepted while a result still waits
// in the output register. The bank reads as zero until written; no clearing pass is
// needed after reset. Configuration registers are to be written only while the block
// is idle; the block itself does not enforce this.
module ppm_sum_decoder_with_register_port
    import ppmsd_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS = 8,
    parameter int unsigned BANK_DEPTH   = 128
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    ppmsd_item_if.sink             item,
    ppmsd_result_if.source         result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencing of one item.
    ppmsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Decoder state, register bank and result register.
    ppmsd_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .BANK_DEPTH   (BANK_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_action     (item.action),
        .in_edge_time  (item.edge_time),
        .in_port_frame (item.port_frame),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .tx_byte       (result.tx_byte),
        .frame_ready   (result.frame_ready)
    );

endmodule

/* rtl/ppmsd_ctrl.sv */
// Controller state machine of the PPM-sum decoder.
module ppmsd_ctrl
    import ppmsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    // The result register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.action == ACTION_RISE || status.action == ACTION_FALL)
                    state_next = ST_PAIR;
                else if (status.action == ACTION_PORT && status.bank_read)
                    state_next = ST_READ;
                else
                    state_next = ST_FINISH;
            end
            ST_PAIR:
            begin
                if (status.have_pair)
                    state_next = ST_PULSE;
                else
                    state_next = ST_FINISH;
            end
            ST_PULSE:
            begin
                if (status.publish && !status.copy_none)
                    state_next = ST_COPY;
                else
                    state_next = ST_FINISH;
            end
            ST_COPY:
            begin
                if (status.copy_last)
                    state_next = ST_FINISH;
            end
            ST_READ:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic: datapath commands for the current state.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.capture = in_valid;
            ST_EXEC:
            begin
                cmd.edge_step = (status.action == ACTION_RISE ||
                                 status.action == ACTION_FALL);
                cmd.port_step = (status.action == ACTION_PORT);
            end
            ST_PAIR:   cmd.pair_step = 1'b1;
            ST_PULSE:  cmd.pulse_step = 1'b1;
            ST_COPY:   cmd.copy_step = 1'b1;
            ST_READ:   cmd.read_done = 1'b1;
            ST_FINISH: cmd.load_result = slot_free;
            default:   cmd = '0;
        endcase
    end

    // The result valid flag follows the output transaction.
    always_comb
    begin
        if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/ppmsd_datapath.sv */
// Datapath of the PPM-sum decoder: timing, frame decoding, pulse store and register bank.
module ppmsd_datapath
    import ppmsd_pkg::*;
#(
    parameter int unsigned NUM_CHANNELS = 8,
    parameter int unsigned BANK_DEPTH   = 128
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic [1:0]             in_action,
    input  logic [31:0]            in_edge_time,
    input  logic [15:0]            in_port_frame,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output logic [7:0]             tx_byte,
    output logic                   frame_ready
);

    localparam int unsigned IDX_W  = $clog2(NUM_CHANNELS + 1);
    localparam int unsigned SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int unsigned ADDR_W = $clog2(BANK_DEPTH);
    localparam logic [7:0]  BANK_LIMIT = 8'(BANK_DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(NUM_CHANNELS - 1);
    localparam logic [IDX_W-1:0] FULL_COUNT = IDX_W'(NUM_CHANNELS);

    // Configuration registers.
    logic [15:0] sync_width_reg;
    logic [15:0] min_width_reg;
    logic [15:0] max_width_reg;
    logic [3:0]  min_channels_reg;

    // Captured item.
    logic [1:0]  action_reg;
    logic [31:0] time_reg;
    logic [15:0] frame_reg;

    // Decoder state.
    logic [31:0]      last_time_reg;
    logic [15:0]      low_reg;
    logic [15:0]      high_reg;
    logic [15:0]      width_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             unsynced_reg;
    logic             flag_reg;
    logic [7:0]       reply_reg;
    logic [15:0]      store_mem [NUM_CHANNELS];

    // Frame copy sequencer.
    logic [IDX_W-1:0]  copy_count_reg;
    logic [SLOT_W-1:0] copy_slot_reg;
    logic              copy_hi_reg;

    // Register bank with one valid bit per byte.
    logic [7:0]        bank_mem [BANK_DEPTH];
    logic              bank_valid_reg [BANK_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              rd_valid_reg;

    // Result register.
    logic [7:0] tx_byte_reg;
    logic       frame_ready_reg;

    // Combinational helpers.
    logic [31:0]       dt;
    logic [15:0]       dt_sat;
    logic [16:0]       pair_sum;
    logic              have_pair;
    logic              is_sync;
    logic              in_range;
    logic              full;
    logic              publish;
    logic [6:0]        regno;
    logic              regno_in_bank;
    logic [7:0]        copy_byte;
    logic [15:0]       copy_word;
    logic              bank_wr_en;
    logic [ADDR_W-1:0] bank_wr_addr;
    logic [7:0]        bank_wr_data;

    // Half-period measurement, saturated to 16 bits.
    assign dt       = time_reg - last_time_reg;
    assign dt_sat   = (|dt[31:16]) ? PERIOD_MAX : dt[15:0];
    assign pair_sum = 17'(high_reg) + 17'(low_reg);
    assign have_pair = (high_reg != 16'd0) && (low_reg != 16'd0);

    // Pulse classification against the configured limits.
    assign is_sync  = (width_reg >= sync_width_reg);
    assign in_range = (width_reg >= min_width_reg) && (width_reg <= max_width_reg);
    assign full     = in_range && (idx_reg == LAST_SLOT);
    assign publish  = !flag_reg && !unsynced_reg &&
                      ((is_sync && (16'(idx_reg) >= 16'(min_channels_reg))) ||
                       (!is_sync && full));

    // Serial port frame decoding.
    assign regno         = frame_reg[14:8];
    assign regno_in_bank = ({1'b0, regno} < BANK_LIMIT);

    // Frame copy source: low byte first, then high byte.
    assign copy_byte = 8'({copy_slot_reg, copy_hi_reg});
    assign copy_word = store_mem[copy_slot_reg];

    // Status to the controller.
    assign status.action    = action_reg;
    assign status.bank_read = frame_reg[15] && (regno != REG_READY);
    assign status.have_pair = have_pair;
    assign status.publish   = publish;
    assign status.copy_none = is_sync && (idx_reg == '0);
    assign status.copy_last = copy_hi_reg &&
                              (16'(copy_slot_reg) + 16'd1 == 16'(copy_count_reg));

    // Single bank write port shared by the frame copy and port writes.
    always_comb
    begin
        bank_wr_en   = 1'b0;
        bank_wr_addr = copy_byte[ADDR_W-1:0];
        bank_wr_data = copy_hi_reg ? copy_word[15:8] : copy_word[7:0];
        if (cmd.copy_step)
        begin
            bank_wr_en = (copy_byte < BANK_LIMIT);
        end
        else if (cmd.port_step && !frame_reg[15] && regno != REG_CLEAR_READY)
        begin
            bank_wr_en   = regno_in_bank;
            bank_wr_addr = regno[ADDR_W-1:0];
            bank_wr_data = frame_reg[7:0];
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_width_reg   <= SYNC_WIDTH_RESET;
            min_width_reg    <= MIN_WIDTH_RESET;
            max_width_reg    <= MAX_WIDTH_RESET;
            min_channels_reg <= MIN_CHANNELS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SYNC_WIDTH:   sync_width_reg   <= cfg_wr_data[15:0];
                CFG_MIN_WIDTH:    min_width_reg    <= cfg_wr_data[15:0];
                CFG_MAX_WIDTH:    max_width_reg    <= cfg_wr_data[15:0];
                CFG_MIN_CHANNELS: min_channels_reg <= cfg_wr_data[3:0];
                default:          ;
            endcase
        end
    end

    // Item capture and pulse width payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= in_action;
            time_reg   <= in_edge_time;
            frame_reg  <= in_port_frame;
        end
        if (cmd.pair_step && have_pair)
            width_reg <= pair_sum[16:1];
    end

    // Edge timing and frame decoding state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg  <= '0;
            low_reg        <= '0;
            high_reg       <= '0;
            idx_reg        <= '0;
            unsynced_reg   <= 1'b0;
            flag_reg       <= 1'b0;
            reply_reg      <= '0;
            copy_count_reg <= '0;
            copy_slot_reg  <= '0;
            copy_hi_reg    <= 1'b0;
        end
        else
        begin
            // A rising edge ends a low period, a falling edge a high period.
            if (cmd.edge_step)
            begin
                last_time_reg <= time_reg;
                if (action_reg == ACTION_RISE)
                    low_reg <= dt_sat;
                else
                    high_reg <= dt_sat;
            end

            // A complete pair becomes one pulse width.
            if (cmd.pair_step && have_pair)
            begin
                low_reg  <= '0;
                high_reg <= '0;
            end

            // Channel slot bookkeeping for one pulse.
            if (cmd.pulse_step)
            begin
                if (is_sync)
                begin
                    idx_reg        <= '0;
                    unsynced_reg   <= 1'b0;
                    copy_count_reg <= idx_reg;
                end
                else if (!unsynced_reg && in_range)
                begin
                    if (full)
                    begin
                        idx_reg        <= '0;
                        unsynced_reg   <= 1'b1;
                        copy_count_reg <= FULL_COUNT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                if (publish)
                begin
                    flag_reg      <= 1'b1;
                    copy_slot_reg <= '0;
                    copy_hi_reg   <= 1'b0;
                end
            end

            // Frame copy advances one byte per cycle.
            if (cmd.copy_step)
            begin
                copy_hi_reg <= !copy_hi_reg;
                if (copy_hi_reg)
                    copy_slot_reg <= copy_slot_reg + 1'b1;
            end

            // Serial port frame: flag read, flag clear.
            if (cmd.port_step)
            begin
                if (frame_reg[15] && regno == REG_READY)
                    reply_reg <= {7'd0, flag_reg};
                else if (!frame_reg[15] && regno == REG_CLEAR_READY)
                    flag_reg <= 1'b0;
            end

            // Bank read data, registered at the port step, is taken into the reply in the following read state.
            if (cmd.read_done)
                reply_reg <= rd_valid_reg ? rd_data_reg : 8'd0;
        end
    end

    // Pulse store: written at the current channel slot.
    always_ff @(posedge clk)
    begin
        if (cmd.pulse_step && !is_sync && !unsynced_reg && in_range)
            store_mem[idx_reg[SLOT_W-1:0]] <= width_reg;
    end

    // Register bank memory with registered read.
    always_ff @(posedge clk)
    begin
        if (bank_wr_en)
            bank_mem[bank_wr_addr] <= bank_wr_data;
        if (cmd.port_step)
            rd_data_reg <= bank_mem[regno[ADDR_W-1:0]];
    end

    // Valid bits: an unwritten byte reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BANK_DEPTH; i++)
                bank_valid_reg[i] <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (bank_wr_en)
                bank_valid_reg[bank_wr_addr] <= 1'b1;
            if (cmd.port_step)
                rd_valid_reg <= regno_in_bank && bank_valid_reg[regno[ADDR_W-1:0]];
        end
    end

    // Result register for the output transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            tx_byte_reg     <= reply_reg;
            frame_ready_reg <= flag_reg;
        end
    end

    assign tx_byte     = tx_byte_reg;
    assign frame_ready = frame_ready_reg;

    // The channel slot never reaches the slot count between pulses.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        16'(idx_reg) < 16'(NUM_CHANNELS))
        else $error("channel slot index out of range");

    // While unsynchronized no channel is counted.
    a_unsynced_idle: assert property (@(posedge clk) disable iff (!rst_n)
        unsynced_reg |-> (idx_reg == '0))
        else $error("channel count while unsynchronized");

    // The ready flag rises only through a published frame.
    a_flag_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flag_reg) |-> $past(cmd.pulse_step && publish))
        else $error("ready flag set without a published frame");

    // A frame copy runs only with the ready flag already set.
    a_copy_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_step |-> flag_reg)
        else $error("frame copy without ready flag");

endmodule

/* tb/ppmsd_tb_pkg.sv */
// Reply predictor and in-order checker for the PPM-sum decoder testbench.
`timescale 1ns / 100ps
package ppmsd_tb_pkg;
    import ppmsd_pkg::*;

    localparam int unsigned DECODER_SLOTS = 8;
    localparam int unsigned BANK_BYTES    = 128;

    // One expected result transaction.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_ready;
    } ppm_reply_t;

    class ppm_reply_scoreboard;
        // Configuration as last written through the configuration write port.
        logic [15:0] cfg_sync;
        logic [15:0] cfg_min;
        logic [15:0] cfg_max;
        logic [3:0]  cfg_min_ch;

        // Decoder state as the block should hold it.
        logic [31:0] prev_edge;
        logic [15:0] low_ticks;
        logic [15:0] high_ticks;
        logic [3:0]  slot;
        logic        lost_sync;
        logic [15:0] widths [DECODER_SLOTS];
        logic [7:0]  bank [BANK_BYTES];
        logic        frame_pending;
        logic [7:0]  reply;

        ppm_reply_t  pending_replies[$];
        int unsigned errors;

        function new();
            cfg_sync      = SYNC_WIDTH_RESET;
            cfg_min       = MIN_WIDTH_RESET;
            cfg_max       = MAX_WIDTH_RESET;
            cfg_min_ch    = MIN_CHANNELS_RESET;
            prev_edge     = '0;
            low_ticks     = '0;
            high_ticks    = '0;
            slot          = '0;
            lost_sync     = 1'b0;
            frame_pending = 1'b0;
            reply         = '0;
            errors        = 0;
            foreach (widths[i])
                widths[i] = '0;
            foreach (bank[i])
                bank[i] = '0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] reg_index,
                                   logic [CFG_DATA_W-1:0] data);
            case (reg_index)
                CFG_SYNC_WIDTH:   cfg_sync   = data;
                CFG_MIN_WIDTH:    cfg_min    = data;
                CFG_MAX_WIDTH:    cfg_max    = data;
                CFG_MIN_CHANNELS: cfg_min_ch = data[3:0];
                default: ;
            endcase
        endfunction

        // Copy the first count channel widths into the bank, low byte first.
        function void publish(int unsigned count);
            for (int unsigned i = 0; i < count; i++) begin
                bank[2 * i]     = widths[i][7:0];
                bank[2 * i + 1] = widths[i][15:8];
            end
            frame_pending = 1'b1;
        endfunction

        function void pulse_seen(logic [15:0] width);
            // A sync width closes the frame and resynchronizes the decoder.
            if (width >= cfg_sync) begin
                if (!lost_sync && slot >= cfg_min_ch && !frame_pending)
                    publish(slot);
                slot      = '0;
                lost_sync = 1'b0;
                return;
            end
            if (lost_sync)
                return;
            if (width >= cfg_min && width <= cfg_max && slot < DECODER_SLOTS) begin
                widths[slot] = width;
                slot++;
            end
            // A full frame is published at once and the decoder waits for sync.
            if (slot >= DECODER_SLOTS) begin
                if (!frame_pending)
                    publish(DECODER_SLOTS);
                slot      = '0;
                lost_sync = 1'b1;
            end
        endfunction

        function void edge_seen(logic rising, logic [31:0] stamp);
            logic [31:0] delta;
            logic [16:0] sum;
            delta     = stamp - prev_edge;
            prev_edge = stamp;
            if (delta > {16'h0000, PERIOD_MAX})
                delta = {16'h0000, PERIOD_MAX};
            if (rising)
                low_ticks = delta[15:0];
            else
                high_ticks = delta[15:0];
            // Both half periods known: their mean is one pulse width.
            if (high_ticks != 0 && low_ticks != 0) begin
                sum = {1'b0, high_ticks} + {1'b0, low_ticks};
                pulse_seen(sum[16:1]);
                high_ticks = '0;
                low_ticks  = '0;
            end
        endfunction

        function void port_frame_seen(logic [15:0] frm);
            logic [6:0] reg_no;
            reg_no = frm[14:8];
            if (frm[15]) begin
                if (reg_no == REG_READY)
                    reply = {7'b0, frame_pending};
                else
                    reply = bank[reg_no];
            end else begin
                if (reg_no == REG_CLEAR_READY)
                    frame_pending = 1'b0;
                else
                    bank[reg_no] = frm[7:0];
            end
        endfunction

        // Record an accepted input transaction and queue the reply it causes.
        function void note_item(logic [1:0] act, logic [31:0] stamp, logic [15:0] frm);
            ppm_reply_t expected;
            case (act)
                ACTION_RISE: edge_seen(1'b1, stamp);
                ACTION_FALL: edge_seen(1'b0, stamp);
                ACTION_PORT: port_frame_seen(frm);
                default: ;
            endcase
            expected.tx_byte     = reply;
            expected.frame_ready = frame_pending;
            pending_replies.push_back(expected);
        endfunction

        // Compare one accepted result transaction with the oldest expectation.
        function void check_reply(logic [7:0] tx_byte, logic frame_ready);
            ppm_reply_t expected;
            if (pending_replies.size() == 0) begin
                $error("unexpected result: tx_byte %0h frame_ready %0b", tx_byte, frame_ready);
                errors++;
                return;
            end
            expected = pending_replies.pop_front();
            if (tx_byte !== expected.tx_byte) begin
                $error("tx_byte mismatch: expected %0h, actual %0h",
                       expected.tx_byte, tx_byte);
                errors++;
            end
            if (frame_ready !== expected.frame_ready) begin
                $error("frame_ready mismatch: expected %0b, actual %0b",
                       expected.frame_ready, frame_ready);
                errors++;
            end
        endfunction
    endclass

endpackage

/* tb/tb_top.sv */
// Top level of the PPM-sum decoder testbench: clock, reset, stimulus and checking.
`timescale 1ns / 100ps
module tb_top;
    import ppmsd_pkg::*;
    import ppmsd_tb_pkg::*;

    localparam logic [1:0]  ACTION_UNUSED  = 2'd3;
    localparam int unsigned DIRECTED_ITEMS = 26;
    localparam int unsigned PHASE_ITEMS    = 305;
    localparam int unsigned NUM_PHASES     = 6;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned STALL_LIMIT    = 3000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    ppmsd_item_if   item_ch();
    ppmsd_result_if result_ch();

    ppm_reply_scoreboard sb = new();
    logic [31:0]         now_ticks;
    int unsigned         items_sent;
    bit                  no_idle;
    bit                  hold_request;

    ppm_sum_decoder_with_register_port dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one input transaction and hold it until the block takes it.
    task automatic send_item(input logic [1:0] act, input logic [31:0] stamp,
                             input logic [15:0] frm);
        item_ch.valid      <= 1'b1;
        item_ch.action     <= act;
        item_ch.edge_time  <= stamp;
        item_ch.port_frame <= frm;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_item(act, stamp, frm);
        items_sent++;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Drain the block completely so that configuration may change.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] reg_index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= reg_index;
        cfg_wr_data <= data;
        @(posedge clk);
        sb.set_register(reg_index, data);
    endtask

    task automatic write_config(input logic [15:0] sync_v, input logic [15:0] min_v,
                                input logic [15:0] max_v, input logic [15:0] min_ch_v);
        write_register(CFG_SYNC_WIDTH, sync_v);
        write_register(CFG_MIN_WIDTH, min_v);
        write_register(CFG_MAX_WIDTH, max_v);
        write_register(CFG_MIN_CHANNELS, min_ch_v);
        cfg_wr_en <= 1'b0;
    endtask

    // A rising and a falling edge whose half periods average to the given width. The
    // leading edge is chosen to replace a pending half period instead of pairing with it.
    task automatic send_pulse(input int unsigned width);
        int unsigned w;
        int unsigned span;
        int unsigned lo;
        int unsigned hi;
        int unsigned first;
        logic [1:0]  lead;
        logic [1:0]  trail;
        w = (width == 0) ? 1 : ((width > 32'h0000ffff) ? 32'h0000ffff : width);
        span = 2 * w + $urandom_range(0, 1);
        if (span > 131070)
            span = 131070;
        lo    = (span > 65535) ? span - 65535 : 1;
        hi    = (span - 1 > 65535) ? 65535 : span - 1;
        first = $urandom_range(lo, hi);
        if (sb.high_ticks != 0)
            lead = ACTION_FALL;
        else if (sb.low_ticks != 0)
            lead = ACTION_RISE;
        else
            lead = ($urandom_range(0, 1) != 0) ? ACTION_RISE : ACTION_FALL;
        trail = (lead == ACTION_RISE) ? ACTION_FALL : ACTION_RISE;
        now_ticks += first;
        send_item(lead, now_ticks, 16'($urandom));
        now_ticks += span - first;
        send_item(trail, now_ticks, 16'($urandom));
    endtask

    // A run of channel pulses, some out of range or on a boundary, then a sync.
    task automatic send_frame();
        int unsigned n;
        int unsigned w;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10)
                                        : $urandom_range(sb.cfg_min_ch, 8);
        for (int unsigned k = 0; k < n; k++) begin
            case ($urandom_range(0, 11))
                0:       w = $urandom_range(1, sb.cfg_min);
                1:       w = $urandom_range(sb.cfg_max, sb.cfg_sync);
                2:       w = sb.cfg_min;
                3:       w = sb.cfg_max;
                4:       w = sb.cfg_sync - 1;
                default: w = $urandom_range(sb.cfg_min, sb.cfg_max);
            endcase
            send_pulse(w);
        end
        w = ($urandom_range(0, 3) == 0) ? sb.cfg_sync : $urandom_range(sb.cfg_sync, 16'hffff);
        send_pulse(w);
    endtask

    // A few serial port frames: flag reads, flag clears, bank reads and writes.
    task automatic send_port_ops();
        int unsigned n;
        logic [6:0]  reg_no;
        n = $urandom_range(1, 3);
        for (int unsigned k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0: send_item(ACTION_PORT, $urandom, {1'b1, REG_READY, 8'($urandom)});
                1: send_item(ACTION_PORT, $urandom, {1'b0, REG_CLEAR_READY, 8'($urandom)});
                2, 3:
                begin
                    reg_no = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 15))
                                                         : 7'($urandom);
                    send_item(ACTION_PORT, $urandom, {1'b1, reg_no, 8'($urandom)});
                end
                default:
                begin
                    reg_no = 7'($urandom);
                    send_item(ACTION_PORT, $urandom, {1'b0, reg_no, 8'($urandom)});
                end
            endcase
        end
    endtask

    // Stray transactions: unused action, long gaps, zero gaps, lone edges.
    task automatic send_noise();
        logic [1:0] dir;
        dir = ($urandom_range(0, 1) != 0) ? ACTION_RISE : ACTION_FALL;
        case ($urandom_range(0, 3))
            0: send_item(ACTION_UNUSED, $urandom, 16'($urandom));
            1:
            begin
                now_ticks += $urandom;
                send_item(dir, now_ticks, 16'($urandom));
            end
            2: send_item(dir, now_ticks, 16'($urandom));
            default:
            begin
                now_ticks += $urandom_range(1, 3000);
                send_item(dir, now_ticks, 16'($urandom));
            end
        endcase
    endtask

    // Result side: check each accepted transaction, then pick the next ready value.
    initial
    begin
        int unsigned stall_left;
        int unsigned hold_left;
        bit          next_ready;
        stall_left = 0;
        hold_left  = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                sb.check_reply(result_ch.tx_byte, result_ch.frame_ready);
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                next_ready   = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            result_ch.ready <= next_ready;
        end
    end

    // Watchdog: too long without any transaction on either channel.
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus: reset, directed checks under reset configuration, random phases.
    initial
    begin
        int unsigned phase_end;
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_index          <= CFG_SYNC_WIDTH;
        cfg_wr_data        <= '0;
        item_ch.valid      <= 1'b0;
        item_ch.action     <= ACTION_RISE;
        item_ch.edge_time  <= '0;
        item_ch.port_frame <= '0;
        now_ticks    = '0;
        items_sent   = 0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unused action and a flag read straight after reset.
        send_item(ACTION_UNUSED, $urandom, 16'($urandom));
        send_item(ACTION_PORT, $urandom, {1'b1, REG_READY, 8'h00});
        // Zero gap, then a saturated gap, then a wrap of the timer that syncs.
        send_item(ACTION_RISE, 32'h0000_0000, 16'($urandom));
        send_item(ACTION_FALL, 32'hffff_ffff, 16'($urandom));
        send_item(ACTION_RISE, 32'h0000_0010, 16'($urandom));
        now_ticks = 32'h0000_0010;
        // Five channels on and inside the limits, two skipped, then a sync.
        send_pulse(MIN_WIDTH_RESET);
        send_pulse(MAX_WIDTH_RESET);
        send_pulse(MIN_WIDTH_RESET - 1);
        send_pulse(SYNC_WIDTH_RESET - 1);
        send_pulse(1500);
        send_pulse(1000);
        send_pulse(2000);
        send_pulse(SYNC_WIDTH_RESET);
        // Flag read, bank read, flag clear, write to the flag's number, flag read.
        send_item(ACTION_PORT, $urandom, {1'b1, REG_READY, 8'($urandom)});
        send_item(ACTION_PORT, $urandom, {1'b1, 7'd1, 8'($urandom)});
        send_item(ACTION_PORT, $urandom, {1'b0, REG_CLEAR_READY, 8'($urandom)});
        send_item(ACTION_PORT, $urandom, {1'b0, REG_READY, 8'ha5});
        send_item(ACTION_PORT, $urandom, {1'b1, REG_READY, 8'h00});

        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: write_config(16'hffff, 16'h0000, 16'hffff, 16'd8);
                1: write_config(16'h0000, 16'h0000, 16'h0000, 16'd0);
                2: write_config(16'd3000, 16'd2000, 16'd1000, {12'hfff, 4'd0});
                3, 4:
                    write_config(16'($urandom_range(2400, 3500)), 16'($urandom_range(600, 1000)),
                                 16'($urandom_range(1800, 2300)),
                                 {12'($urandom), 4'($urandom_range(0, 8))});
                default:
                    write_config(SYNC_WIDTH_RESET, MIN_WIDTH_RESET, MAX_WIDTH_RESET,
                                 {12'h000, MIN_CHANNELS_RESET});
            endcase
            // Long hold-off on the result side while the input keeps offering.
            if (p == 3)
                hold_request = 1'b1;
            phase_end = DIRECTED_ITEMS + (p + 1) * PHASE_ITEMS;
            while (items_sent < phase_end) begin
                no_idle = (p == NUM_PHASES - 1) || ($urandom_range(0, 7) == 0);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: send_frame();
                    6, 7, 8:          send_port_ops();
                    default:          send_noise();
                endcase
            end
        end

        settle();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
